[src/tta_pkg.sv]
`timescale 1ns / 1ps

package tta_pkg;

    // Fixed field widths of the configuration registers and the source digits.
    localparam int DIGIT_WIDTH     = 16;
    localparam int RANK_WIDTH      = 3;
    localparam int ORDER_WIDTH     = 8;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int HW_AXES         = 4;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_RANK    = 4;
    localparam int DEF_INDEX_WIDTH = 32;
    localparam int DEF_ELEM_WIDTH  = 64;

    // Register values after reset; the axis order is the identity permutation.
    localparam logic [RANK_WIDTH-1:0]  RANK_RESET  = 3'd1;
    localparam logic [DIGIT_WIDTH-1:0] SIZE_RESET  = 16'd1;
    localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = 8'd228;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_RANK  = 3'd0,
        REG_SIZE0 = 3'd1,
        REG_SIZE1 = 3'd2,
        REG_SIZE2 = 3'd3,
        REG_SIZE3 = 3'd4,
        REG_ORDER = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_STRIDE,
        PH_DIGIT,
        PH_WRAP,
        PH_DONE
    } phase_t;

    // Status from the register file to the address datapath.
    typedef struct packed {
        logic                restart;
        logic [RANK_WIDTH:0] rank_eff;
    } cfg_status_t;

endpackage

[src/tta_regs.sv]
`timescale 1ns / 1ps

module tta_regs
    import tta_pkg::*;
#(
    parameter int MAX_RANK = DEF_MAX_RANK
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]       cfg_data,
    output cfg_status_t                     status,
    output logic [DIGIT_WIDTH-1:0]          axis_len [MAX_RANK],
    output logic [((MAX_RANK > 4) ? $clog2(MAX_RANK) : 2)-1:0] axis_src [MAX_RANK]
);

    localparam int PERM_W     = (MAX_RANK > 4) ? $clog2(MAX_RANK) : 2;
    localparam int RANK_EXT_W = RANK_WIDTH + 1;

    logic [RANK_WIDTH-1:0]  rank_reg;
    logic [DIGIT_WIDTH-1:0] size_reg [HW_AXES];
    logic [ORDER_WIDTH-1:0] order_reg;
    logic [RANK_EXT_W-1:0]  rank_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg  <= RANK_RESET;
            order_reg <= ORDER_RESET;
            for (int i = 0; i < HW_AXES; i++)
            begin
                size_reg[i] <= SIZE_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RANK:  rank_reg    <= cfg_data[RANK_WIDTH-1:0];
                REG_SIZE0: size_reg[0] <= cfg_data;
                REG_SIZE1: size_reg[1] <= cfg_data;
                REG_SIZE2: size_reg[2] <= cfg_data;
                REG_SIZE3: size_reg[3] <= cfg_data;
                REG_ORDER: order_reg   <= cfg_data[ORDER_WIDTH-1:0];
                default:   ;
            endcase
        end
    end

    // A rank of zero acts as one; a rank above the supported maximum is clipped.
    always_comb
    begin
        if (rank_reg == '0)
        begin
            rank_eff = RANK_EXT_W'(1);
        end
        else if ({1'b0, rank_reg} > RANK_EXT_W'(MAX_RANK))
        begin
            rank_eff = RANK_EXT_W'(MAX_RANK);
        end
        else
        begin
            rank_eff = {1'b0, rank_reg};
        end
    end

    assign status.restart  = cfg_we;
    assign status.rank_eff = rank_eff;

    // Unused axes and zero lengths act as length one. Output axes past the
    // fourth map to the source axis of the same number.
    for (genvar a = 0; a < MAX_RANK; a++)
    begin : g_axis
        if (a < HW_AXES)
        begin : g_cfg
            assign axis_len[a] = (RANK_EXT_W'(a) < rank_eff && size_reg[a] != '0)
                               ? size_reg[a] : DIGIT_WIDTH'(1);
            assign axis_src[a] = PERM_W'(order_reg[2*a +: 2]);
        end
        else
        begin : g_fixed
            assign axis_len[a] = DIGIT_WIDTH'(1);
            assign axis_src[a] = PERM_W'(a);
        end
    end

endmodule

[src/tensor_transpose_address_gen.sv]
`timescale 1ns / 1ps

// Destination address generator for an N-axis tensor transpose.
//
// Source elements enter on the input channel (in_valid, in_ready, elem_value)
// in row-major source order, one item per element. Each item leaves on the
// output channel (out_valid, out_ready) as one item carrying dest_index, the
// element's flat index in the transposed tensor, the value unchanged, and
// last_elem on the final element. After the final element the source digit
// counter wraps to zero, ready for the next tensor.
//
// The output is registered: an item accepted at a clock edge is presented
// on the output right after that edge. Throughput is one item per cycle
// when not stalled; the destination index is kept as a running sum and each
// item adds one precomputed per-axis step, so only one add sits per item.
//
// After reset, and after every configuration write, a setup sequencer builds
// the strides, rebases the index on the saved digits and builds the per-axis
// steps with one shared multiplier; in_ready stays low during that time.
// Digits survive writes. When the receiver stalls, the output register holds
// its item and in_ready falls until that item is taken.

module tensor_transpose_address_gen
    import tta_pkg::*;
#(
    parameter int MAX_RANK    = DEF_MAX_RANK,
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
    parameter int ELEM_WIDTH  = DEF_ELEM_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ELEM_WIDTH-1:0]      elem_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [INDEX_WIDTH-1:0]     dest_index,
    output logic [ELEM_WIDTH-1:0]      out_value,
    output logic                       last_elem
);

    localparam int AXIS_IDX_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int RANK_CNT_W = $clog2(MAX_RANK + 1);
    localparam int PERM_W     = (MAX_RANK > 4) ? $clog2(MAX_RANK) : 2;
    localparam int PERM_EXT_W = PERM_W + 1;
    localparam int PROD_W     = INDEX_WIDTH + DIGIT_WIDTH;
    localparam logic [PERM_EXT_W-1:0] PERM_LIMIT = PERM_EXT_W'(MAX_RANK);
    localparam logic [AXIS_IDX_W-1:0] LAST_STEP  = AXIS_IDX_W'(MAX_RANK - 1);

    cfg_status_t             cfg_status;
    logic [DIGIT_WIDTH-1:0]  axis_len [MAX_RANK];
    logic [PERM_W-1:0]       axis_src [MAX_RANK];
    logic [RANK_CNT_W-1:0]   rank_eff;

    phase_t                  phase_reg, phase_next;
    logic [AXIS_IDX_W-1:0]   step_reg, step_next;
    logic                    step_last;

    logic [INDEX_WIDTH-1:0]  run_reg;
    logic [INDEX_WIDTH-1:0]  acc_reg;
    logic [INDEX_WIDTH-1:0]  dest_reg, dest_next;
    logic [INDEX_WIDTH-1:0]  stride_reg [MAX_RANK];
    logic [INDEX_WIDTH-1:0]  delta_reg  [MAX_RANK];
    logic [DIGIT_WIDTH-1:0]  digit_reg  [MAX_RANK];
    logic [DIGIT_WIDTH-1:0]  digit_next [MAX_RANK];

    // Setup datapath selection
    logic [RANK_CNT_W-1:0]   step_ext;
    logic [RANK_CNT_W-1:0]   out_axis_full;
    logic [AXIS_IDX_W-1:0]   out_axis;
    logic                    stride_live;
    logic [PERM_W-1:0]       src_p;
    logic                    src_ok;
    logic [AXIS_IDX_W-1:0]   src_idx;
    logic [AXIS_IDX_W-1:0]   wrap_idx;
    logic [AXIS_IDX_W-1:0]   axis_sel;
    logic [AXIS_IDX_W-1:0]   len_sel_idx;
    logic [DIGIT_WIDTH-1:0]  sel_len;
    logic [DIGIT_WIDTH-1:0]  sel_top;
    logic [DIGIT_WIDTH-1:0]  sel_digit;
    logic [DIGIT_WIDTH-1:0]  d_clamp;
    logic [INDEX_WIDTH-1:0]  sel_stride;
    logic [INDEX_WIDTH-1:0]  mul_a;
    logic [DIGIT_WIDTH-1:0]  mul_b;
    logic [PROD_W-1:0]       mul_full;
    logic [INDEX_WIDTH-1:0]  mul_lo;

    // Streaming path
    logic [MAX_RANK-1:0]     at_top;
    logic                    last_cur;
    logic                    inc_found;
    logic [INDEX_WIDTH-1:0]  inc_delta;
    logic                    in_fire;

    logic                    out_valid_reg;
    logic [INDEX_WIDTH-1:0]  dest_index_reg;
    logic [ELEM_WIDTH-1:0]   out_value_reg;
    logic                    last_elem_reg;

    tta_regs #(
        .MAX_RANK (MAX_RANK)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (cfg_status),
        .axis_len  (axis_len),
        .axis_src  (axis_src)
    );

    assign rank_eff = cfg_status.rank_eff[RANK_CNT_W-1:0];

    // ------------------------------------------------------------------
    // Setup sequencer. Three passes of MAX_RANK steps each:
    //   stride pass: output axes from last to first, each writes the running
    //     product into the stride of its source axis, then scales the product
    //     by that axis's length.
    //   digit pass: sums each saved digit, clamped to its axis length minus one,
    //     times its stride into the running destination index. The saved digits
    //     themselves are left alone.
    //   wrap pass: from the fastest axis down, the step added when axis j
    //     counts up is its stride minus what the faster axes give back when
    //     they wrap to zero.
    // ------------------------------------------------------------------
    assign step_ext      = RANK_CNT_W'(step_reg);
    assign stride_live   = step_ext < rank_eff;
    assign out_axis_full = rank_eff - RANK_CNT_W'(1) - step_ext;
    assign out_axis      = out_axis_full[AXIS_IDX_W-1:0];
    assign src_p         = axis_src[out_axis];
    assign src_ok        = {1'b0, src_p} < PERM_LIMIT;
    assign src_idx       = src_p[AXIS_IDX_W-1:0];
    assign wrap_idx      = LAST_STEP - step_reg;
    assign step_last     = step_reg == LAST_STEP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STRIDE;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        axis_sel    = step_reg;
        len_sel_idx = step_reg;
        mul_a       = run_reg;
        mul_b       = '0;

        case (phase_reg)
            PH_STRIDE:
            begin
                len_sel_idx = src_idx;
                mul_a       = run_reg;
                mul_b       = src_ok ? sel_len : DIGIT_WIDTH'(1);
            end
            PH_DIGIT:
            begin
                mul_a = sel_stride;
                mul_b = d_clamp;
            end
            PH_WRAP:
            begin
                axis_sel    = wrap_idx;
                len_sel_idx = wrap_idx;
                mul_a       = sel_stride;
                mul_b       = sel_top;
            end
            PH_DONE:
            begin
                mul_b = '0;
            end
            default:
            begin
                mul_b = '0;
            end
        endcase

        if (cfg_status.restart)
        begin
            phase_next = PH_STRIDE;
            step_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PH_STRIDE, PH_DIGIT, PH_WRAP:
                begin
                    if (step_last)
                    begin
                        step_next = '0;
                        case (phase_reg)
                            PH_STRIDE: phase_next = PH_DIGIT;
                            PH_DIGIT:  phase_next = PH_WRAP;
                            default:   phase_next = PH_DONE;
                        endcase
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                PH_DONE:
                begin
                    step_next = '0;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    assign sel_len    = axis_len[len_sel_idx];
    assign sel_top    = sel_len - 1'b1;
    assign sel_stride = stride_reg[axis_sel];
    assign sel_digit  = digit_reg[axis_sel];
    assign d_clamp    = (sel_digit > sel_top) ? sel_top : sel_digit;

    // One shared multiplier serves all three passes.
    assign mul_full = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign mul_lo   = mul_full[INDEX_WIDTH-1:0];

    // ------------------------------------------------------------------
    // Streaming counter. The fastest axis that is not at its top counts up,
    // every faster axis wraps to zero, and the running index moves by that
    // axis's step. When all axes are at their top the tensor is done and
    // everything returns to zero. A digit left above its axis length by a
    // size change counts as the top of that axis and is stored back
    // saturated.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < MAX_RANK; j++)
    begin : g_top
        assign at_top[j] = digit_reg[j] >= (axis_len[j] - 1'b1);
    end

    assign last_cur = &at_top;

    always_comb
    begin
        inc_found = 1'b0;
        inc_delta = '0;
        for (int j = MAX_RANK - 1; j >= 0; j--)
        begin
            digit_next[j] = at_top[j] ? (axis_len[j] - 1'b1) : digit_reg[j];
            if (!inc_found)
            begin
                if (at_top[j])
                begin
                    digit_next[j] = '0;
                end
                else
                begin
                    digit_next[j] = digit_reg[j] + 1'b1;
                    inc_delta     = delta_reg[j];
                    inc_found     = 1'b1;
                end
            end
        end
        dest_next = inc_found ? (dest_reg + inc_delta) : '0;
    end

    assign in_ready = (phase_reg == PH_DONE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= INDEX_WIDTH'(1);
            acc_reg  <= '0;
            dest_reg <= '0;
            for (int i = 0; i < MAX_RANK; i++)
            begin
                stride_reg[i] <= '0;
                delta_reg[i]  <= '0;
                digit_reg[i]  <= '0;
            end
        end
        else
        begin
            // Digits change only when an item is taken.
            if (in_fire)
            begin
                for (int i = 0; i < MAX_RANK; i++)
                begin
                    digit_reg[i] <= digit_next[i];
                end
            end

            if (cfg_status.restart)
            begin
                run_reg  <= INDEX_WIDTH'(1);
                acc_reg  <= '0;
                dest_reg <= '0;
                for (int i = 0; i < MAX_RANK; i++)
                begin
                    stride_reg[i] <= '0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_STRIDE:
                    begin
                        if (stride_live)
                        begin
                            if (src_ok)
                            begin
                                stride_reg[src_idx] <= run_reg;
                            end
                            run_reg <= mul_lo;
                        end
                    end
                    PH_DIGIT:
                    begin
                        dest_reg <= dest_reg + mul_lo;
                    end
                    PH_WRAP:
                    begin
                        delta_reg[wrap_idx] <= sel_stride - acc_reg;
                        acc_reg             <= acc_reg + mul_lo;
                    end
                    PH_DONE:
                    begin
                        if (in_fire)
                        begin
                            dest_reg <= dest_next;
                        end
                    end
                    default:
                    begin
                        acc_reg <= acc_reg;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dest_index_reg <= dest_reg;
            out_value_reg  <= elem_value;
            last_elem_reg  <= last_cur;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dest_index = dest_index_reg;
    assign out_value  = out_value_reg;
    assign last_elem  = last_elem_reg;

`ifndef NO_ASSERTIONS
    // An accepted item always lands in the output register.
    a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item did not reach the output register");

    // A configuration write restarts setup, so no item is taken right after it.
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("input accepted while setup was restarting");

    // Taking the final element wraps the counter and the running index to zero.
    a_last_wraps_counter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_cur |=> dest_reg == '0 && digit_reg[0] == '0)
        else $error("counter did not wrap after the final element");
`endif

endmodule
